### hdl/rhpm_pkg.sv
// Shared types and constants for the red hue pixel mask block.
// Holds the HSV result type, the fixed-point constants and the window table.
// No dependencies.
package rhpm_pkg;

   // Fixed-point reciprocals: 12 fractional bits, rounded to nearest
   localparam int unsigned FixShift = 12;
   localparam int unsigned FixHalf  = 2048;
   localparam int unsigned SatNum   = 2088960;   // 2 * 255 * 4096
   localparam int unsigned HueNum   = 245760;    // 2 * 30 * 4096
   localparam int unsigned SatRecW  = 20;        // round(255*4096/1) < 2**20
   localparam int unsigned HueRecW  = 17;        // round(30*4096/1) < 2**17
   localparam int unsigned NumWin   = 9;
   localparam logic [8:0]  HueWrap  = 9'd180;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } hsv_type;

   typedef struct packed {
      logic [7:0] hlo;
      logic [7:0] slo;
      logic [7:0] vlo;
      logic [7:0] hhi;
      logic [7:0] shi;
      logic [7:0] vhi;
   } window_type;

   // Inclusive HSV windows, bit i of the enable register selects entry i
   localparam window_type WINDOWS [NumWin] = '{
      '{8'd0,   8'd25, 8'd98, 8'd11,  8'd39,  8'd144},
      '{8'd156, 8'd30, 8'd79, 8'd179, 8'd93,  8'd151},
      '{8'd0,   8'd25, 8'd60, 8'd35,  8'd40,  8'd75},
      '{8'd169, 8'd28, 8'd78, 8'd173, 8'd90,  8'd152},
      '{8'd157, 8'd28, 8'd58, 8'd177, 8'd78,  8'd81},
      '{8'd142, 8'd67, 8'd44, 8'd165, 8'd102, 8'd104},
      '{8'd0,   8'd50, 8'd50, 8'd10,  8'd255, 8'd255},
      '{8'd160, 8'd50, 8'd50, 8'd180, 8'd255, 8'd255},
      '{8'd110, 8'd30, 8'd75, 8'd160, 8'd75,  8'd120}
   };

endpackage

### hdl/rhpm_ifs.sv
// Handshake channels of the red hue pixel mask block.
// Pixel request channel and mask/HSV response channel; no dependencies.
interface rhpm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] blue;
   logic [7:0] green;
   logic [7:0] red;

   modport source (output valid, output blue, output green, output red, input ready);
   modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

interface rhpm_rsp_if;
   logic       valid;
   logic       ready;
   logic       red_mask;
   logic [7:0] hue;
   logic [7:0] saturation;
   logic [7:0] brightness;

   modport source (output valid, output red_mask, output hue, output saturation,
                   output brightness, input ready);
   modport sink   (input valid, input red_mask, input hue, input saturation,
                   input brightness, output ready);
endinterface

### hdl/rhpm_hsv_conv.sv
// Four-stage BGR to 8-bit HSV converter with reciprocal tables.
// Depends on rhpm_pkg.
module rhpm_hsv_conv (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [7:0]       in_blue,
   input  logic [7:0]       in_green,
   input  logic [7:0]       in_red,
   output logic             out_valid,
   input  logic             out_ready,
   output rhpm_pkg::hsv_type out_hsv
);
   import rhpm_pkg::*;

   // Reciprocal tables, built at elaboration
   logic [SatRecW-1:0] sat_tab [256];
   logic [HueRecW-1:0] hue_tab [256];

   for (genvar i = 0; i < 256; i++) begin : g_tab
      localparam int unsigned Den = 2 * i + ((i == 0) ? 1 : 0);
      localparam int unsigned SatRec = (i == 0) ? 0 : (SatNum + i) / Den;
      localparam int unsigned HueRec = (i == 0) ? 0 : (HueNum + i) / Den;
      assign sat_tab[i] = SatRec[SatRecW-1:0];
      assign hue_tab[i] = HueRec[HueRecW-1:0];
   end

   // Stage enables: a stage loads when empty or when its successor moves
   logic en1, en2, en3, en4;
   logic vld1_ff, vld2_ff, vld3_ff, vld4_ff;

   assign en4      = !vld4_ff || out_ready;
   assign en3      = !vld3_ff || en4;
   assign en2      = !vld2_ff || en3;
   assign en1      = !vld1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         if (en1) vld1_ff <= in_valid;
         if (en2) vld2_ff <= vld1_ff;
         if (en3) vld3_ff <= vld2_ff;
         if (en4) vld4_ff <= vld3_ff;
      end
   end

   // Stage 1: max, min, spread and hue sector numerator
   logic [7:0]        val1_in, min1, diff1_in;
   logic signed [11:0] hnum1_in, sb, sg, sr, sd;
   logic [7:0]        val1_ff, diff1_ff;
   logic signed [11:0] hnum1_ff;

   always_comb begin
      val1_in = in_blue;
      min1    = in_blue;
      if (in_green > val1_in) val1_in = in_green;
      if (in_red > val1_in)   val1_in = in_red;
      if (in_green < min1)    min1 = in_green;
      if (in_red < min1)      min1 = in_red;
      diff1_in = val1_in - min1;
      sb = $signed({4'b0, in_blue});
      sg = $signed({4'b0, in_green});
      sr = $signed({4'b0, in_red});
      sd = $signed({4'b0, diff1_in});
      if (val1_in == in_red)
         hnum1_in = sg - sb;
      else if (val1_in == in_green)
         hnum1_in = sb - sr + (sd <<< 1);
      else
         hnum1_in = sr - sg + (sd <<< 2);
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         val1_ff  <= val1_in;
         diff1_ff <= diff1_in;
         hnum1_ff <= hnum1_in;
      end
   end

   // Stage 2: reciprocal lookups
   logic [7:0]         val2_ff, diff2_ff;
   logic signed [11:0] hnum2_ff;
   logic [SatRecW-1:0] srec2_ff;
   logic [HueRecW-1:0] hrec2_ff;

   always_ff @(posedge clock) begin
      if (en2) begin
         val2_ff  <= val1_ff;
         diff2_ff <= diff1_ff;
         hnum2_ff <= hnum1_ff;
         srec2_ff <= sat_tab[val1_ff];
         hrec2_ff <= hue_tab[diff1_ff];
      end
   end

   // Stage 3: the two multiplications
   logic [27:0]        sprod3_in, sprod3_ff;
   logic signed [29:0] hprod3_in, hprod3_ff;
   logic [7:0]         val3_ff;

   assign sprod3_in = 28'(diff2_ff * srec2_ff);
   assign hprod3_in = 30'($signed(hnum2_ff) * $signed({1'b0, hrec2_ff}));

   always_ff @(posedge clock) begin
      if (en3) begin
         sprod3_ff <= sprod3_in;
         hprod3_ff <= hprod3_in;
         val3_ff   <= val2_ff;
      end
   end

   // Stage 4: round, floor shift and hue wrap
   logic [27:0]        ssum4;
   logic signed [29:0] hsum4;
   logic [8:0]         hq4;
   hsv_type            hsv4_in, hsv4_ff;

   always_comb begin
      ssum4 = sprod3_ff + 28'(FixHalf);
      hsum4 = hprod3_ff + 30'(FixHalf);
      hq4   = hsum4[FixShift+8:FixShift];
      if (hsum4[29]) hq4 = hq4 + HueWrap;
      hsv4_in.hue        = hq4[7:0];
      hsv4_in.saturation = ssum4[FixShift+7:FixShift];
      hsv4_in.brightness = val3_ff;
   end

   always_ff @(posedge clock) begin
      if (en4) hsv4_ff <= hsv4_in;
   end

   assign out_valid = vld4_ff;
   assign out_hsv   = hsv4_ff;

endmodule

### hdl/rhpm_window_match.sv
// Window test stage and output register of the red hue pixel mask block.
// Depends on rhpm_pkg.
module rhpm_window_match (
   input  logic              clock,
   input  logic              reset,
   input  logic [8:0]        window_enable,
   input  logic              in_valid,
   output logic              in_ready,
   input  rhpm_pkg::hsv_type in_hsv,
   output logic              out_valid,
   input  logic              out_ready,
   output logic              out_mask,
   output rhpm_pkg::hsv_type out_hsv
);
   import rhpm_pkg::*;

   logic          en;
   logic          vld_ff;
   logic          mask_in, mask_ff;
   logic [NumWin-1:0] hit;
   hsv_type       hsv_ff;

   assign en       = !vld_ff || out_ready;
   assign in_ready = en;

   // Per-window inclusive bounds check, gated by its enable bit
   always_comb begin
      for (int i = 0; i < NumWin; i++) begin
         hit[i] = window_enable[i] &&
                  in_hsv.hue >= WINDOWS[i].hlo && in_hsv.hue <= WINDOWS[i].hhi &&
                  in_hsv.saturation >= WINDOWS[i].slo &&
                  in_hsv.saturation <= WINDOWS[i].shi &&
                  in_hsv.brightness >= WINDOWS[i].vlo &&
                  in_hsv.brightness <= WINDOWS[i].vhi;
      end
      mask_in = |hit;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (en) vld_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mask_ff <= mask_in;
         hsv_ff  <= in_hsv;
      end
   end

   assign out_valid = vld_ff;
   assign out_mask  = mask_ff;
   assign out_hsv   = hsv_ff;

endmodule

### hdl/red_hue_pixel_mask.sv
// Red hue pixel mask top level: HSV conversion pipeline plus window match.
// Depends on rhpm_pkg, rhpm_ifs, rhpm_hsv_conv and rhpm_window_match.
//
// Takes one BGR pixel beat per clock unless stalled and returns one response
// beat per pixel, in order, carrying the 8-bit HSV value (hue 0..179) and a
// mask bit that is set when the pixel lies inside any enabled color window.
// Throughput is one pixel per clock when not stalled. There are five register
// stages (min/max, reciprocal lookup, multiply, rounding, window compare); the
// first loads at the edge that accepts the request. Backpressure on the response
// stalls the whole pipeline and empty stages keep accepting. csr_write_data[i]
// enables window i; reset enables all nine.
module red_hue_pixel_mask (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [8:0]  csr_write_data,
   rhpm_req_if.sink    req_chan,
   rhpm_rsp_if.source  rsp_chan
);
   import rhpm_pkg::*;

   logic [8:0] window_enable_ff;
   logic       mid_valid, mid_ready;
   hsv_type    mid_hsv, rsp_hsv;

   // Window enable register
   always_ff @(posedge clock) begin
      if (reset) window_enable_ff <= 9'h1ff;
      else if (csr_write_enable) window_enable_ff <= csr_write_data;
   end

   rhpm_hsv_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_blue   (req_chan.blue),
      .in_green  (req_chan.green),
      .in_red    (req_chan.red),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_hsv   (mid_hsv)
   );

   rhpm_window_match u_match (
      .clock         (clock),
      .reset         (reset),
      .window_enable (window_enable_ff),
      .in_valid      (mid_valid),
      .in_ready      (mid_ready),
      .in_hsv        (mid_hsv),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .out_mask      (rsp_chan.red_mask),
      .out_hsv       (rsp_hsv)
   );

   assign rsp_chan.hue        = rsp_hsv.hue;
   assign rsp_chan.saturation = rsp_hsv.saturation;
   assign rsp_chan.brightness = rsp_hsv.brightness;

endmodule
